// ===== src/rdc_pkg.sv =====
// Shared types and constants of the radix digit converter.
// Used by rdc_div, radix_digit_converter_core and tb_top; depends on nothing.
package rdc_pkg;

  localparam int DIGIT_W     = 6;
  localparam int REG_W       = 6;
  localparam int CHAR_W      = 7;
  localparam int COUNT_W     = 6;
  localparam int CFG_ADDR_W  = 1;
  localparam int MAX_RESULTS = 32;
  localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 1'd1;

  localparam logic [REG_W-1:0] BASE_MIN      = 6'd2;
  localparam logic [REG_W-1:0] BASE_MAX      = 6'd37;
  localparam logic [REG_W-1:0] BASE_RESET    = 6'd10;
  localparam logic [REG_W-1:0] CAPACITY_RESET = 6'd33;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
  localparam logic [DIGIT_W-1:0] TEN       = 6'd10;

  typedef struct packed {
    logic               done;
    logic               more;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    if (d < TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d) - CHAR_W'(TEN);
  endfunction

endpackage

// ===== src/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rdc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// Depends on rdc_pkg; used by radix_digit_converter_core.
module rdc_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        load,
  input  logic [VALUE_WIDTH-1:0]      value,
  input  logic [rdc_pkg::DIGIT_W-1:0] base,
  output rdc_pkg::div_status_t        status
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0]      quot;
  logic [rdc_pkg::DIGIT_W-1:0] rem;
  logic [rdc_pkg::DIGIT_W-1:0] rem_next;
  logic [rdc_pkg::DIGIT_W:0]   trial;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        nonzero;
  logic                        done;
  logic                        ge;

  assign trial    = {rem, quot[VALUE_WIDTH-1]};
  assign ge       = trial >= {1'b0, base};
  assign rem_next = ge ? rdc_pkg::DIGIT_W'(trial - {1'b0, base}) : trial[rdc_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(VALUE_WIDTH);
        rem     <= '0;
        nonzero <= 1'b0;
        if (load) begin
          quot <= value;
        end
      end else if (busy) begin
        quot    <= {quot[VALUE_WIDTH-2:0], ge};
        rem     <= rem_next;
        nonzero <= nonzero | ge;
        cnt     <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.more = nonzero;
  assign status.rem  = rem;

endmodule

// ===== src/radix_digit_converter_core.sv =====
// Top level of the radix digit converter: unsigned value to ASCII digits.
// Depends on rdc_pkg, rdc_div and rdc_ram.
//
// Usage:
//   s_* takes one request: s_tdata = value (padded to whole bytes).
//   m_* gives one request per character, most significant digit first:
//     m_tdata = digit_char, digit_count, truncated (from bit 0 up),
//     m_tuser = char_valid, m_tlast = final character of the value.
//   When no character fits, a single request with m_tuser low is given.
//   cfg_we/cfg_addr/cfg_wdata write base (index 0) and string_capacity
//   (index 1); write only while the block is idle.
// Sequence:
//   Digits come one after another from the bit-serial divider; then the
//   output is sized and each character is read from the digit stack RAM.
//   One value is handled at a time; s_tready is high only when idle.
// Reset and stall:
//   Reset empties the output register, returns to idle and sets base 10
//   and capacity 33. A stalled receiver holds the output register and the
//   character sequence waits; a new value is taken while the last
//   character still waits.
module radix_digit_converter_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,   // value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rdc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // digit_char, digit_count, truncated
  output logic                                 m_tuser,   // char_valid
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [rdc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [rdc_pkg::REG_W-1:0]            cfg_wdata
);

  localparam int TOT_W = $clog2(VALUE_WIDTH + 1);
  localparam int PTR_W = $clog2(MAX_DIGITS);
  localparam int CMP_W = (TOT_W > 7) ? TOT_W : 7;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_EMPTY = 6'b001000,
    ST_READ  = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [rdc_pkg::REG_W-1:0]    base;
  logic [rdc_pkg::REG_W-1:0]    capacity;
  logic [rdc_pkg::REG_W-1:0]    base_clamped;
  logic [TOT_W-1:0]             total;
  logic [PTR_W-1:0]             wp;
  logic [PTR_W-1:0]             rp;
  logic [rdc_pkg::LEFT_W-1:0]   left;
  logic                         trunc;
  logic                         accept;
  logic                         div_start;
  logic                         out_free;
  logic                         ram_we;
  logic                         ram_re;
  logic [rdc_pkg::DIGIT_W-1:0]  ram_rdata;
  rdc_pkg::div_status_t         div_st;
  logic [CMP_W-1:0]             held;
  logic [CMP_W-1:0]             room;
  logic [CMP_W-1:0]             emit_a;
  logic [CMP_W-1:0]             emit;
  logic [rdc_pkg::CHAR_W-1:0]   out_char;
  logic [rdc_pkg::COUNT_W-1:0]  out_count;
  logic                         out_trunc;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = accept || (state == ST_DIV && div_st.done && div_st.more);
  assign ram_we    = (state == ST_DIV) && div_st.done;
  assign ram_re    = (state == ST_READ);

  assign base_clamped = (base < rdc_pkg::BASE_MIN) ? rdc_pkg::BASE_MIN :
                        (base > rdc_pkg::BASE_MAX) ? rdc_pkg::BASE_MAX : base;

  assign held   = (CMP_W'(total) > CMP_W'(MAX_DIGITS)) ? CMP_W'(MAX_DIGITS) : CMP_W'(total);
  assign room   = (capacity == '0) ? '0 : CMP_W'(capacity - rdc_pkg::REG_W'(1));
  assign emit_a = (held > room) ? room : held;
  assign emit   = (emit_a > CMP_W'(rdc_pkg::MAX_RESULTS)) ? CMP_W'(rdc_pkg::MAX_RESULTS)
                                                          : emit_a;

  rdc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .load   (accept),
    .value  (s_tdata[VALUE_WIDTH-1:0]),
    .base   (base_clamped),
    .status (div_st)
  );

  rdc_ram #(
    .WIDTH (rdc_pkg::DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (div_st.rem),
    .re    (ram_re),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done && !div_st.more) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = (emit == '0) ? ST_EMPTY : ST_READ;
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = (left == rdc_pkg::LEFT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      base     <= rdc_pkg::BASE_RESET;
      capacity <= rdc_pkg::CAPACITY_RESET;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_addr == rdc_pkg::REG_BASE) begin
        base <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == rdc_pkg::REG_CAPACITY) begin
        capacity <= cfg_wdata;
      end
      if ((state == ST_LOAD || state == ST_EMPTY) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      total <= '0;
      wp    <= '0;
    end
    if (ram_we) begin
      total <= total + TOT_W'(1);
      wp    <= (wp == PTR_W'(MAX_DIGITS - 1)) ? '0 : wp + PTR_W'(1);
    end
    if (state == ST_PREP) begin
      left  <= rdc_pkg::LEFT_W'(emit);
      trunc <= CMP_W'(total) > room;
      rp    <= (wp == '0) ? PTR_W'(MAX_DIGITS - 1) : wp - PTR_W'(1);
    end
    if (state == ST_LOAD && out_free) begin
      left      <= left - rdc_pkg::LEFT_W'(1);
      rp        <= (rp == '0) ? PTR_W'(MAX_DIGITS - 1) : rp - PTR_W'(1);
      out_char  <= rdc_pkg::digit_to_ascii(ram_rdata);
      out_count <= rdc_pkg::COUNT_W'(total);
      out_trunc <= trunc;
      m_tuser   <= 1'b1;
      m_tlast   <= (left == rdc_pkg::LEFT_W'(1));
    end
    if (state == ST_EMPTY && out_free) begin
      out_char  <= '0;
      out_count <= rdc_pkg::COUNT_W'(total);
      out_trunc <= trunc;
      m_tuser   <= 1'b0;
      m_tlast   <= 1'b1;
    end
  end

  assign m_tdata = {{(rdc_pkg::OUT_TDATA_W - rdc_pkg::CHAR_W - rdc_pkg::COUNT_W - 1){1'b0}},
                    out_trunc, out_count, out_char};

`ifndef SYNTHESIS
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIV)
    else $error("request accepted but division did not start");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_READ) |-> left != '0)
    else $error("character load with no characters left");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |-> (total != '0 && total <= TOT_W'(VALUE_WIDTH)))
    else $error("digit count out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty result not marked last");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for radix_digit_converter_core: drives values and register writes,
// predicts every output request (digit or empty) and checks it against the master side.
// Depends on rdc_pkg and the RTL of radix_digit_converter_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       char_valid;
    logic       last;
    logic [5:0] digit_count;
    logic       truncated;
  } char_rec_t;

  class radix_string_book;
    logic [5:0] base_r;
    logic [5:0] cap_r;
    char_rec_t  expected_chars[$];
    int         mismatches;
    int         shown;

    function new();
      base_r = 6'd10;
      cap_r = 6'd33;
      mismatches = 0;
      shown = 0;
    endfunction

    function void set_reg(logic [rdc_pkg::CFG_ADDR_W-1:0] idx, logic [5:0] val);
      case (idx)
        rdc_pkg::REG_BASE: base_r = val;
        rdc_pkg::REG_CAPACITY: cap_r = val;
        default: ;
      endcase
    endfunction

    function void add_value(logic [31:0] v);
      logic [5:0] digs [32];
      logic [31:0] q;
      int radix;
      int total;
      int room;
      int emit;
      logic trunc;
      char_rec_t rec;
      radix = (base_r < 2) ? 2 : ((base_r > 37) ? 37 : int'(base_r));
      q = v;
      total = 0;
      do begin
        digs[total] = 6'(q % radix);
        q = q / radix;
        total++;
      end while (q != 0);
      room = (cap_r > 0) ? int'(cap_r) - 1 : 0;
      trunc = (total > room);
      emit = total;
      if (emit > room) emit = room;
      if (emit > 32) emit = 32;
      if (emit == 0) begin
        rec = '{7'd0, 1'b0, 1'b1, 6'(total), trunc};
        expected_chars.push_back(rec);
      end else begin
        for (int i = 0; i < emit; i++) begin
          rec.digit_char = (digs[total-1-i] < 10) ? 7'(8'h30 + digs[total-1-i])
                                                   : 7'(8'h41 + digs[total-1-i] - 10);
          rec.char_valid = 1'b1;
          rec.last = (i + 1 == emit);
          rec.digit_count = 6'(total);
          rec.truncated = trunc;
          expected_chars.push_back(rec);
        end
      end
    endfunction

    function void check_char(char_rec_t got);
      char_rec_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("unexpected request: char=%h valid=%b last=%b count=%0d trunc=%b",
                   got.digit_char, got.char_valid, got.last, got.digit_count, got.truncated);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected char=%h valid=%b last=%b count=%0d trunc=%b",
                   want.digit_char, want.char_valid, want.last, want.digit_count,
                   want.truncated);
          $display("          actual   char=%h valid=%b last=%b count=%0d trunc=%b",
                   got.digit_char, got.char_valid, got.last, got.digit_count,
                   got.truncated);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // value
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // digit_char, digit_count, truncated
  logic        m_tuser;   // char_valid
  logic        m_tlast;
  logic        cfg_we;
  logic [rdc_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [rdc_pkg::REG_W-1:0]      cfg_wdata;

  radix_string_book book;
  int src_gap_pct;
  int sink_stall_pct;

  radix_digit_converter_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      book.check_char('{m_tdata[6:0], m_tuser, m_tlast, m_tdata[12:7], m_tdata[13]});
    end
  end

  task automatic send_value(logic [31:0] v);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = v;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.add_value(v);
    @(negedge clk);
  endtask

  task automatic drain_chars();
    s_tvalid = 1'b0;
    while (book.expected_chars.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [rdc_pkg::CFG_ADDR_W-1:0] idx, logic [5:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    book.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_radix(logic [5:0] b, logic [5:0] cap);
    drain_chars();
    write_reg(rdc_pkg::REG_BASE, b);
    write_reg(rdc_pkg::REG_CAPACITY, cap);
  endtask

  function automatic logic [31:0] pick_value(logic [5:0] b);
    int radix;
    longint p;
    int k;
    radix = (b < 2) ? 2 : ((b > 37) ? 37 : int'(b));
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1000);
      2: begin
        p = 1;
        k = $urandom_range(1, 32);
        repeat (k) if (p * radix <= 64'h1_0000_0000) p = p * radix;
        return 32'(p - $urandom_range(1));
      end
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    logic [5:0] b;
    logic [5:0] cap;
    logic [5:0] base_edges [6];
    logic [5:0] cap_edges [6];
    base_edges = '{6'd0, 6'd1, 6'd2, 6'd37, 6'd38, 6'd63};
    cap_edges = '{6'd0, 6'd1, 6'd2, 6'd33, 6'd34, 6'd63};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = rdc_pkg::REG_BASE;
    cfg_wdata = '0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    book = new();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    set_radix(6'd2, 6'd33);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    set_radix(6'd37, 6'd33);
    send_value(32'd36);
    send_value(32'd37);
    send_value(32'hFFFF_FFFF);
    set_radix(6'd16, 6'd4);
    send_value(32'h0012_3456);
    send_value(32'h0000_0ABC);
    set_radix(6'd10, 6'd1);
    send_value(32'd5);
    set_radix(6'd0, 6'd0);
    send_value(32'd0);
    send_value(32'd6);
    set_radix(6'd1, 6'd2);
    send_value(32'd3);
    set_radix(6'd38, 6'd34);
    send_value(32'hFFFF_FFFF);
    set_radix(6'd63, 6'd63);
    send_value(32'd1368);
    set_radix(6'd2, 6'd63);
    send_value(32'hFFFF_FFFF);

    for (int blk = 0; blk < 12; blk++) begin
      b = ($urandom_range(3) == 0) ? base_edges[$urandom_range(5)]
                                   : 6'($urandom_range(2, 37));
      cap = ($urandom_range(3) == 0) ? cap_edges[$urandom_range(5)]
                                     : 6'($urandom_range(1, 33));
      set_radix(b, cap);
      case (blk % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 50; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 50; end
        default: begin src_gap_pct = 23; sink_stall_pct = 23; end
      endcase
      repeat (16) send_value(pick_value(b));
    end

    drain_chars();
    repeat (40) @(negedge clk);
    if (book.mismatches == 0 && book.expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
